### rtl/core/ypf_pkg.sv
// Package for the YMODEM packet framer: byte codes, event codes and the
// command record passed from the front end to the result stage.
// No dependencies.
package ypf_pkg;

   // Line bytes
   localparam logic [7:0] BYTE_SOH  = 8'h01;
   localparam logic [7:0] BYTE_STX  = 8'h02;
   localparam logic [7:0] BYTE_EOT  = 8'h04;
   localparam logic [7:0] BYTE_CA   = 8'h18;
   localparam logic [7:0] BYTE_ESC  = 8'h1B;
   localparam logic [7:0] BYTE_ABT1 = 8'h41;
   localparam logic [7:0] BYTE_ABT2 = 8'h61;

   // Event codes on the result channel
   localparam logic [2:0] EV_PAYLOAD = 3'd0;
   localparam logic [2:0] EV_OK      = 3'd1;
   localparam logic [2:0] EV_BADSEQ  = 3'd2;
   localparam logic [2:0] EV_EOT     = 3'd3;
   localparam logic [2:0] EV_SABORT  = 3'd4;
   localparam logic [2:0] EV_UABORT  = 3'd5;
   localparam logic [2:0] EV_ERROR   = 3'd6;
   localparam logic [2:0] EV_IDLE_TO = 3'd7;

   // Packet geometry (positions count bytes after the start byte)
   localparam logic [10:0] HEADER_LEN = 11'd2;
   localparam logic [10:0] SHORT_LEN  = 11'd128;
   localparam logic [10:0] LONG_LEN   = 11'd1024;
   localparam logic [10:0] SHORT_CRC_POS = 11'd130;
   localparam logic [10:0] LONG_CRC_POS  = 11'd1026;

   // Command queue between front end and result stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      CMD_PAYLOAD,
      CMD_VERDICT,
      CMD_EVENT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   ev;          // simple events only
      logic [7:0]   data;        // payload byte
      logic [9:0]   offset;      // payload offset
      logic [7:0]   seq;         // verdict: sequence byte
      logic [7:0]   seq_comp;    // verdict: complement byte
      logic         long_packet; // verdict: 1024-byte packet
      logic [15:0]  crc;         // verdict: received CRC
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/core/ymodem_packet_framer_unit.sv
// YMODEM packet framer, top level.
// Request channel: push a request (req_kind, req_rx_byte) while req_full is
//    low; each request is one received byte or one receive-timeout tick.
//    Requests are taken every cycle while req_full is low; a request that
//    yields no result (a start byte, a header byte, the first CA, the CRC
//    high byte) still passes through the framer in its cycle.
// Result channel: while rsp_empty is low the oldest result is on the rsp_
//    ports; rsp_pop takes it. At most one result per request, in order.
// Path: the framer writes the command queue at the edge that takes a
//    request, and the output register loads the command from the queue
//    once that register is free or being taken. Throughput: one request per
//    cycle while req_full is low; the framer state updates on each request.
// Stalls: if the receiver holds off, results gather in a four-entry command
//    queue behind the output register; req_full rises once that queue is
//    full and drops the cycle after the output register takes a command.
// Reset (synchronous): framer back to idle, queue and output register
//    emptied; nothing reaches the result side until new requests arrive.
// Depends on ypf_pkg, ypf_front, ypf_queue, ypf_back.
module ymodem_packet_framer_unit import ypf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_offset,
   output logic [7:0]  rsp_seq_num,
   output logic [10:0] rsp_packet_len,
   output logic [15:0] rsp_crc_value
);

   queue_status_type q_status;
   cmd_type          front_cmd;
   cmd_type          head_cmd;
   logic             front_push;
   logic             back_pop;
   logic             accept;

   // hold requests off while the queue has no room
   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   // classify each request and advance the framing state
   ypf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .cmd_push    (front_push),
      .cmd         (front_cmd)
   );

   // decouple the framer from the result side
   ypf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (front_push),
      .wr_cmd (front_cmd),
      .pop    (back_pop),
      .rd_cmd (head_cmd),
      .status (q_status)
   );

   // build result fields and hold them until taken
   ypf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (head_cmd),
      .q_status       (q_status),
      .cmd_pop        (back_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_event_res  (rsp_event_res),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_seq_num    (rsp_seq_num),
      .rsp_packet_len (rsp_packet_len),
      .rsp_crc_value  (rsp_crc_value)
   );

endmodule

### rtl/core/ypf_front.sv
// Front end of the YMODEM packet framer: tracks the framing state per
// request and classifies it into a command for the result stage.
// Depends on ypf_pkg.
module ypf_front import ypf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CAWAIT,
      PH_PACKET
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [10:0] byte_pos_ff, byte_pos_in;
   logic        long_ff, long_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  seq_comp_ff, seq_comp_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [10:0] crc_pos;
   logic [10:0] pos_m2;

   assign crc_pos = long_ff ? LONG_CRC_POS : SHORT_CRC_POS;
   assign pos_m2  = byte_pos_ff - HEADER_LEN;

   always_comb begin
      phase_in    = phase_ff;
      byte_pos_in = byte_pos_ff;
      long_in     = long_ff;
      seq_in      = seq_ff;
      seq_comp_in = seq_comp_ff;
      crc_high_in = crc_high_ff;
      cmd_push    = 1'b0;
      cmd         = '0;
      cmd.kind    = CMD_EVENT;
      if (accept) begin
         case (phase_ff)
            PH_CAWAIT: begin
               phase_in = PH_IDLE;
               cmd_push = 1'b1;
               cmd.ev   = (!req_kind && req_rx_byte == BYTE_CA) ? EV_SABORT : EV_ERROR;
            end
            PH_PACKET: begin
               if (req_kind) begin
                  // drop the packet
                  phase_in    = PH_IDLE;
                  byte_pos_in = '0;
                  cmd_push    = 1'b1;
                  cmd.ev      = EV_ERROR;
               end else begin
                  byte_pos_in = byte_pos_ff + 11'd1;
                  if (byte_pos_ff == 11'd0) begin
                     seq_in = req_rx_byte;
                  end else if (byte_pos_ff == 11'd1) begin
                     seq_comp_in = req_rx_byte;
                  end else if (byte_pos_ff < crc_pos) begin
                     cmd_push   = 1'b1;
                     cmd.kind   = CMD_PAYLOAD;
                     cmd.data   = req_rx_byte;
                     cmd.offset = pos_m2[9:0];
                  end else if (byte_pos_ff == crc_pos) begin
                     crc_high_in = req_rx_byte;
                  end else begin
                     phase_in         = PH_IDLE;
                     byte_pos_in      = '0;
                     cmd_push         = 1'b1;
                     cmd.kind         = CMD_VERDICT;
                     cmd.seq          = seq_ff;
                     cmd.seq_comp     = seq_comp_ff;
                     cmd.long_packet  = long_ff;
                     cmd.crc          = {crc_high_ff, req_rx_byte};
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (req_kind) begin
                  cmd_push = 1'b1;
                  cmd.ev   = EV_IDLE_TO;
               end else begin
                  case (req_rx_byte)
                     BYTE_SOH, BYTE_STX: begin
                        phase_in    = PH_PACKET;
                        byte_pos_in = '0;
                        long_in     = (req_rx_byte == BYTE_STX);
                     end
                     BYTE_EOT: begin
                        cmd_push = 1'b1;
                        cmd.ev   = EV_EOT;
                     end
                     BYTE_CA: begin
                        phase_in = PH_CAWAIT;
                     end
                     BYTE_ABT1, BYTE_ABT2, BYTE_ESC: begin
                        cmd_push = 1'b1;
                        cmd.ev   = EV_UABORT;
                     end
                     default: begin
                        cmd_push = 1'b1;
                        cmd.ev   = EV_ERROR;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         byte_pos_ff <= '0;
         long_ff     <= 1'b0;
         seq_ff      <= '0;
         seq_comp_ff <= '0;
         crc_high_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         byte_pos_ff <= byte_pos_in;
         long_ff     <= long_in;
         seq_ff      <= seq_in;
         seq_comp_ff <= seq_comp_in;
         crc_high_ff <= crc_high_in;
      end
   end

endmodule

### rtl/core/ypf_queue.sv
// Short command queue between the framer front end and the result stage.
// Depends on ypf_pkg.
module ypf_queue import ypf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          wr_cmd,
   input  logic             pop,
   output cmd_type          rd_cmd,
   output queue_status_type status
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

### rtl/core/ypf_back.sv
// Result stage of the YMODEM packet framer: turns queued commands into
// result fields (verdict check, packet length) held in an output register.
// Depends on ypf_pkg.
module ypf_back import ypf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  queue_status_type q_status,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_event_res,
   output logic [7:0]       rsp_data_byte,
   output logic [9:0]       rsp_offset,
   output logic [7:0]       rsp_seq_num,
   output logic [10:0]      rsp_packet_len,
   output logic [15:0]      rsp_crc_value
);

   logic        valid_ff, valid_in;
   logic [2:0]  event_ff, event_in;
   logic [7:0]  data_ff, data_in;
   logic [9:0]  offset_ff, offset_in;
   logic [7:0]  seq_ff, seq_in;
   logic [10:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic        load;

   // advance when the output register is free or being taken
   assign load    = !valid_ff || rsp_pop;
   assign cmd_pop = load && !q_status.empty;

   always_comb begin
      event_in  = EV_ERROR;
      data_in   = '0;
      offset_in = '0;
      seq_in    = '0;
      len_in    = '0;
      crc_in    = '0;
      case (cmd.kind)
         CMD_PAYLOAD: begin
            event_in  = EV_PAYLOAD;
            data_in   = cmd.data;
            offset_in = cmd.offset;
         end
         CMD_VERDICT: begin
            event_in = (cmd.seq == ~cmd.seq_comp) ? EV_OK : EV_BADSEQ;
            seq_in   = cmd.seq;
            len_in   = cmd.long_packet ? LONG_LEN : SHORT_LEN;
            crc_in   = cmd.crc;
         end
         CMD_EVENT: begin
            event_in = cmd.ev;
         end
         default: begin
            event_in = EV_ERROR;
         end
      endcase
      valid_in = load ? !q_status.empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         event_ff  <= event_in;
         data_ff   <= data_in;
         offset_ff <= offset_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         crc_ff    <= crc_in;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_event_res  = event_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_offset     = offset_ff;
   assign rsp_seq_num    = seq_ff;
   assign rsp_packet_len = len_ff;
   assign rsp_crc_value  = crc_ff;

endmodule

### tb/sv/ypf_frame_checker.sv
// Scoreboard for the YMODEM packet framer. It follows the request and result
// queues, predicts every result and compares each accepted one field by field.
// Depends on ypf_pkg for the line bytes, event codes and packet geometry.
`timescale 1ns / 100ps

module ypf_frame_checker import ypf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [2:0]  rsp_event_res,
   input  logic [7:0]  rsp_data_byte,
   input  logic [9:0]  rsp_offset,
   input  logic [7:0]  rsp_seq_num,
   input  logic [10:0] rsp_packet_len,
   input  logic [15:0] rsp_crc_value,
   output int          fail_count,
   output int          events_due
);

   typedef enum logic [1:0] {
      LINK_IDLE,
      LINK_CA_SEEN,
      LINK_IN_PACKET
   } link_phase_type;

   typedef struct packed {
      logic [2:0]  ev;
      logic [7:0]  data;
      logic [9:0]  offset;
      logic [7:0]  seq;
      logic [10:0] len;
      logic [15:0] crc;
   } frame_event_type;

   link_phase_type  link_phase;
   logic [10:0]     rx_pos;
   logic            long_pkt;
   logic [7:0]      seq_byte;
   logic [7:0]      seq_comp;
   logic [7:0]      crc_hi;
   frame_event_type expected_events[$];
   int              errors = 0;

   task automatic report_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= 100)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Advance the framer state by one request and queue the event it yields.
   task automatic predict_frame_event(input logic tmo, input logic [7:0] b);
      frame_event_type e;
      logic [10:0]     len;
      logic [10:0]     pos;
      logic            gives;
      e     = '0;
      gives = 1'b1;
      len   = long_pkt ? LONG_LEN : SHORT_LEN;
      pos   = rx_pos;
      case (link_phase)
         LINK_CA_SEEN: begin
            link_phase = LINK_IDLE;
            e.ev = (!tmo && b == BYTE_CA) ? EV_SABORT : EV_ERROR;
         end
         LINK_IN_PACKET: begin
            if (tmo) begin
               link_phase = LINK_IDLE;
               rx_pos     = '0;
               e.ev       = EV_ERROR;
            end else begin
               rx_pos = pos + 11'd1;
               if (pos == 11'd0) begin
                  seq_byte = b;
                  gives    = 1'b0;
               end else if (pos == 11'd1) begin
                  seq_comp = b;
                  gives    = 1'b0;
               end else if (pos < len + HEADER_LEN) begin
                  e.ev     = EV_PAYLOAD;
                  e.data   = b;
                  e.offset = 10'(pos - HEADER_LEN);
               end else if (pos == len + HEADER_LEN) begin
                  crc_hi = b;
                  gives  = 1'b0;
               end else begin
                  link_phase = LINK_IDLE;
                  rx_pos     = '0;
                  e.ev       = (seq_byte == ~seq_comp) ? EV_OK : EV_BADSEQ;
                  e.seq      = seq_byte;
                  e.len      = len;
                  e.crc      = {crc_hi, b};
               end
            end
         end
         default: begin
            link_phase = LINK_IDLE;
            if (tmo) begin
               e.ev = EV_IDLE_TO;
            end else begin
               case (b)
                  BYTE_SOH, BYTE_STX: begin
                     link_phase = LINK_IN_PACKET;
                     rx_pos     = '0;
                     long_pkt   = (b == BYTE_STX);
                     gives      = 1'b0;
                  end
                  BYTE_EOT: e.ev = EV_EOT;
                  BYTE_CA: begin
                     link_phase = LINK_CA_SEEN;
                     gives      = 1'b0;
                  end
                  BYTE_ABT1, BYTE_ABT2, BYTE_ESC: e.ev = EV_UABORT;
                  default: e.ev = EV_ERROR;
               endcase
            end
         end
      endcase
      if (gives)
         expected_events.push_back(e);
   endtask

   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         link_phase = LINK_IDLE;
         rx_pos     = '0;
         long_pkt   = 1'b0;
         seq_byte   = '0;
         seq_comp   = '0;
         crc_hi     = '0;
         expected_events.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_events.size() == 0) begin
               report_mismatch("result with no request pending, event_res", -1, rsp_event_res);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_res !== want.ev)
                  report_mismatch("event_res", want.ev, rsp_event_res);
               if (rsp_data_byte !== want.data)
                  report_mismatch("data_byte", want.data, rsp_data_byte);
               if (rsp_offset !== want.offset)
                  report_mismatch("offset", want.offset, rsp_offset);
               if (rsp_seq_num !== want.seq)
                  report_mismatch("seq_num", want.seq, rsp_seq_num);
               if (rsp_packet_len !== want.len)
                  report_mismatch("packet_len", want.len, rsp_packet_len);
               if (rsp_crc_value !== want.crc)
                  report_mismatch("crc_value", want.crc, rsp_crc_value);
            end
         end
         if (req_push && !req_full)
            predict_frame_event(req_kind, req_rx_byte);
      end
      fail_count <= errors;
      events_due <= expected_events.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the YMODEM packet framer testbench: clock, reset, request stimulus
// and a randomly stalling result receiver; the verdict comes from the checker.
// Depends on ypf_pkg, ypf_frame_checker and ymodem_packet_framer_unit.
`timescale 1ns / 100ps

module testbench;
   import ypf_pkg::*;

   // Stop the random part once this many requests have gone in.
   localparam int ITEM_TARGET = 1700;
   // Worst case is roughly 2000 requests, each behind a long sender gap and a
   // long receiver stall; allow several times that.
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic        req_kind    = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_pop     = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_offset;
   logic [7:0]  rsp_seq_num;
   logic [10:0] rsp_packet_len;
   logic [15:0] rsp_crc_value;
   int          fail_count;
   int          events_due;
   int          cycle_count = 0;
   int          sent        = 0;
   int          idle_pct    = 0;

   always #2 clock = ~clock;

   ymodem_packet_framer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_event_res  (rsp_event_res),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_seq_num    (rsp_seq_num),
      .rsp_packet_len (rsp_packet_len),
      .rsp_crc_value  (rsp_crc_value)
   );

   ypf_frame_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_event_res  (rsp_event_res),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_seq_num    (rsp_seq_num),
      .rsp_packet_len (rsp_packet_len),
      .rsp_crc_value  (rsp_crc_value),
      .fail_count     (fail_count),
      .events_due     (events_due)
   );

   // Watchdog: abandon the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Gap length: mostly from the lowest range, now and then a long one that lets
   // the command queue fill up and req_full rise.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 3);
      if (roll < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request and hold it until the block takes it. An optional gap
   // goes in front; push is lowered once and raised once, never in one step.
   task automatic send_request(input logic tmo, input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = pick_gap();
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_kind    <= tmo;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      sent++;
   endtask

   // Frame one packet: start byte, sequence byte, complement, data, CRC.
   // A timeout replaces the byte at position cut_at when cut_at is not -1;
   // the packet is then dropped by the block, so stop sending it.
   task automatic send_packet(input bit long_pkt, input bit seq_good, input int cut_at);
      int         len;
      int         pos;
      logic [7:0] seq;
      len = long_pkt ? LONG_LEN : SHORT_LEN;
      seq = 8'($urandom);
      send_request(1'b0, long_pkt ? BYTE_STX : BYTE_SOH);
      for (pos = 0; pos < len + 4; pos++) begin
         if (pos == cut_at) begin
            send_request(1'b1, 8'($urandom));
            return;
         end
         if (pos == 0)
            send_request(1'b0, seq);
         else if (pos == 1)
            send_request(1'b0, seq_good ? ~seq : seq ^ 8'($urandom_range(1, 255)));
         else
            send_request(1'b0, 8'($urandom));
      end
   endtask

   // Result receiver: pop freely, with stalls whose density changes now and
   // then, including stretches with no stalls at all.
   initial begin
      int stall;
      int stall_pct;
      stall     = 0;
      stall_pct = 20;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 399) == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 30;
               default: stall_pct = 60;
            endcase
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_pop <= 1'b0;
            stall = pick_gap() - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int  roll;
      int  cut;
      bit  long_done;
      long_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every idle event, every way out of the CA wait, and a
      // timeout inside each packet size.
      send_request(1'b1, 8'hFF);         // idle timeout, byte lines all ones
      send_request(1'b0, BYTE_EOT);
      send_request(1'b0, BYTE_ABT1);
      send_request(1'b0, BYTE_ABT2);
      send_request(1'b0, BYTE_ESC);
      send_request(1'b0, 8'h00);         // unknown bytes at both extremes
      send_request(1'b0, 8'hFF);
      send_request(1'b0, BYTE_CA);       // sender abort
      send_request(1'b0, BYTE_CA);
      send_request(1'b0, BYTE_CA);       // CA, then a stray byte
      send_request(1'b0, 8'h00);
      send_request(1'b0, BYTE_CA);       // CA, then a timeout
      send_request(1'b1, 8'h00);
      send_request(1'b0, BYTE_CA);       // a start byte after CA is eaten
      send_request(1'b0, BYTE_SOH);
      send_request(1'b0, 8'h42);         // so this one is an idle error
      send_packet(1'b0, 1'b1, 1);        // timeout after the sequence byte
      send_packet(1'b1, 1'b1, 0);        // timeout straight after STX

      // Random part: mostly framed packets with random content, the rest
      // CA pairs and loose idle traffic. One long packet goes in mid-run.
      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            2:       idle_pct = 20;
            default: idle_pct = 50;
         endcase
         roll = $urandom_range(0, 99);
         if (!long_done && sent >= 900) begin
            send_packet(1'b1, $urandom_range(0, 3) != 0, -1);
            long_done = 1'b1;
         end else if (roll < 45) begin
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SHORT_LEN + 3) : -1;
            send_packet(1'b0, $urandom_range(0, 1) != 0, cut);
         end else if (roll < 60) begin
            send_request(1'b0, BYTE_CA);
            case ($urandom_range(0, 2))
               0:       send_request(1'b0, BYTE_CA);
               1:       send_request(1'b0, 8'($urandom));
               default: send_request(1'b1, 8'($urandom));
            endcase
         end else begin
            case ($urandom_range(0, 5))
               0:       send_request(1'b1, 8'($urandom));
               1:       send_request(1'b0, BYTE_EOT);
               2:       send_request(1'b0, BYTE_ABT1);
               3:       send_request(1'b0, BYTE_ABT2);
               4:       send_request(1'b0, BYTE_ESC);
               default: send_request(1'b0, 8'($urandom));
            endcase
         end
      end

      // Drain: drop push, let the checker see the last request, then wait for
      // every expected result and a few cycles more for anything stray.
      req_push <= 1'b0;
      @(posedge clock);
      while (events_due != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && events_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
